FILE: rtl/tbo_pkg.sv
// Package for the triangle/box overlap test: widths, register indexes, stage codes.
// Used by tbo_core and triangle_box_overlap_test.
package tbo_pkg;
  localparam int CoordBitsDef = 24;
  localparam int IdBitsDef    = 20;
  localparam int AddrBits     = 5;

  typedef enum logic [1:0] {
    STAGE_NONE  = 2'd0,
    STAGE_BOX   = 2'd1,
    STAGE_PLANE = 2'd2,
    STAGE_EDGE  = 2'd3
  } stage_e;

  typedef enum logic [2:0] {
    REG_CX   = 3'd0,
    REG_CY   = 3'd1,
    REG_CZ   = 3'd2,
    REG_HX   = 3'd3,
    REG_HY   = 3'd4,
    REG_HZ   = 3'd5,
    REG_FULL = 3'd6
  } reg_e;
endpackage

FILE: rtl/tbo_core.sv
// Pipelined separating-axis datapath of the triangle/box overlap test.
// Depends on tbo_pkg; instantiated by triangle_box_overlap_test.
module tbo_core #(
  parameter int CoordBits = tbo_pkg::CoordBitsDef,
  parameter int IdBits    = tbo_pkg::IdBitsDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  logic                              in_valid_i,
  input  logic signed [2:0][2:0][CoordBits-1:0] vtx_i,
  input  logic [IdBits-1:0]                 id_i,
  input  logic signed [2:0][CoordBits-1:0]  ctr_i,
  input  logic [2:0][CoordBits-2:0]         half_i,
  input  logic                              full_i,
  output logic                              out_valid_o,
  output tbo_pkg::stage_e                   stage_o,
  output logic [IdBits-1:0]                 id_o
);
  localparam int VB  = CoordBits + 1;
  localparam int EB  = CoordBits + 2;
  localparam int PB  = 2 * EB + 1;
  localparam int NB  = PB + 1;
  localparam int DB  = NB + VB + 3;
  localparam int SB  = 2 * EB + 2;
  localparam int QB  = SB + 1;
  localparam int RB  = CoordBits + EB;
  localparam int LB  = NB / 2;
  localparam int HB  = NB - LB;
  localparam int DLB = LB + VB + 1;
  localparam int DHB = HB + VB;
  localparam int RLB = LB + CoordBits - 1;
  localparam int RHB = HB + CoordBits - 1;

  // Stage 1: relative vertices, edges, box-axis test.
  logic               v1_q;
  logic signed [2:0][2:0][VB-1:0] rv_q, rv_d;
  logic signed [2:0][2:0][EB-1:0] ed_q, ed_d;
  logic               box1_q, box1_d;
  logic [IdBits-1:0]  id1_q;
  logic               full1_q;

  always_comb begin
    logic signed [VB-1:0] lo, hi, r;
    box1_d = 1'b0;
    for (int i = 0; i < 3; i++) begin
      for (int k = 0; k < 3; k++) begin
        rv_d[i][k] = VB'($signed(vtx_i[i][k])) - VB'($signed(ctr_i[k]));
      end
    end
    for (int k = 0; k < 3; k++) begin
      ed_d[0][k] = EB'($signed(rv_d[1][k])) - EB'($signed(rv_d[0][k]));
      ed_d[1][k] = EB'($signed(rv_d[2][k])) - EB'($signed(rv_d[1][k]));
      ed_d[2][k] = EB'($signed(rv_d[0][k])) - EB'($signed(rv_d[2][k]));
      lo = rv_d[0][k];
      hi = rv_d[0][k];
      for (int i = 1; i < 3; i++) begin
        if ($signed(rv_d[i][k]) < lo) lo = rv_d[i][k];
        if ($signed(rv_d[i][k]) > hi) hi = rv_d[i][k];
      end
      r = VB'($signed({2'b00, half_i[k]}));
      if (lo > r || -r > hi) box1_d = 1'b1;
    end
  end

  // Stage 2: normal products, edge-axis projections and edge-axis radii.
  logic v2_q;
  logic signed [2:0][1:0][PB-1:0] np_q, np_d;
  logic signed [2:0][2:0][2:0][SB-1:0] ep_q, ep_d;
  logic [2:0][2:0][RB-1:0] er_q, er_d;
  logic signed [2:0][VB-1:0] rv2_q;
  logic box2_q, full2_q;
  logic [IdBits-1:0] id2_q;

  always_comb begin
    logic [EB-1:0] ab, ac;
    for (int k = 0; k < 3; k++) begin
      np_d[k][0] = PB'($signed(ed_q[0][(k+1)%3])) * PB'($signed(ed_q[1][(k+2)%3]));
      np_d[k][1] = PB'($signed(ed_q[0][(k+2)%3])) * PB'($signed(ed_q[1][(k+1)%3]));
    end
    // Axis e x u_a: components (b,c) = (a+1,a+2) give p = e_c*v_b - e_b*v_c.
    for (int i = 0; i < 3; i++) begin
      for (int a = 0; a < 3; a++) begin
        for (int j = 0; j < 3; j++) begin
          ep_d[i][a][j] = SB'($signed(ed_q[i][(a+2)%3])) * SB'($signed(rv_q[j][(a+1)%3]))
                        - SB'($signed(ed_q[i][(a+1)%3])) * SB'($signed(rv_q[j][(a+2)%3]));
        end
        ab = ed_q[i][(a+2)%3][EB-1] ? -ed_q[i][(a+2)%3] : ed_q[i][(a+2)%3];
        ac = ed_q[i][(a+1)%3][EB-1] ? -ed_q[i][(a+1)%3] : ed_q[i][(a+1)%3];
        er_d[i][a] = RB'(half_i[(a+1)%3]) * RB'(ab) + RB'(half_i[(a+2)%3]) * RB'(ac);
      end
    end
  end

  // Stage 3: normal components and edge-axis compares.
  logic v3_q;
  logic signed [2:0][NB-1:0] n_q, n_d;
  logic signed [2:0][VB-1:0] rv3_q;
  logic edge3_q, edge3_d;
  logic box3_q, full3_q;
  logic [IdBits-1:0] id3_q;

  always_comb begin
    logic signed [SB-1:0] lo, hi;
    logic signed [QB-1:0] r;
    edge3_d = 1'b0;
    for (int k = 0; k < 3; k++) begin
      n_d[k] = NB'($signed(np_q[k][0])) - NB'($signed(np_q[k][1]));
    end
    for (int i = 0; i < 3; i++) begin
      for (int a = 0; a < 3; a++) begin
        lo = ep_q[i][a][0];
        hi = ep_q[i][a][0];
        for (int j = 1; j < 3; j++) begin
          if ($signed(ep_q[i][a][j]) < lo) lo = ep_q[i][a][j];
          if ($signed(ep_q[i][a][j]) > hi) hi = ep_q[i][a][j];
        end
        r = QB'(er_q[i][a]);
        if (QB'(lo) > r || -r > QB'(hi)) edge3_d = 1'b1;
      end
    end
  end

  // Stage 4: plane products, each split into a low and a high half of the normal.
  logic v4_q;
  logic signed [2:0][DLB-1:0] dl_q, dl_d;
  logic signed [2:0][DHB-1:0] dh_q, dh_d;
  logic [2:0][RLB-1:0] rl_q, rl_d;
  logic [2:0][RHB-1:0] rh_q, rh_d;
  logic edge4_q, box4_q, full4_q;
  logic [IdBits-1:0] id4_q;

  always_comb begin
    logic [NB-1:0] an;
    for (int k = 0; k < 3; k++) begin
      dl_d[k] = DLB'($signed({1'b0, n_q[k][LB-1:0]})) * DLB'($signed(rv3_q[k]));
      dh_d[k] = DHB'($signed(n_q[k][NB-1:LB])) * DHB'($signed(rv3_q[k]));
      an = n_q[k][NB-1] ? -n_q[k] : n_q[k];
      rl_d[k] = RLB'(half_i[k]) * RLB'(an[LB-1:0]);
      rh_d[k] = RHB'(half_i[k]) * RHB'(an[NB-1:LB]);
    end
  end

  // Stage 5: plane dot product and plane radius sums.
  logic v5_q;
  logic signed [DB-1:0] sum_q, sum_d;
  logic [DB-1:0] rad_q, rad_d;
  logic edge5_q, box5_q, full5_q;
  logic [IdBits-1:0] id5_q;

  always_comb begin
    sum_d = '0;
    rad_d = '0;
    for (int k = 0; k < 3; k++) begin
      sum_d = sum_d + (DB'($signed(dh_q[k])) << LB) + DB'($signed(dl_q[k]));
      rad_d = rad_d + (DB'(rh_q[k]) << LB) + DB'(rl_q[k]);
    end
  end

  // Stage 6: plane compare and final stage select.
  logic v6_q;
  tbo_pkg::stage_e st6_q, st6_d;
  logic [IdBits-1:0] id6_q;

  always_comb begin
    logic [DB-1:0] m;
    m = sum_q[DB-1] ? -sum_q : sum_q;
    if (box5_q) st6_d = tbo_pkg::STAGE_BOX;
    else if (m > rad_q) st6_d = tbo_pkg::STAGE_PLANE;
    else if (full5_q && edge5_q) st6_d = tbo_pkg::STAGE_EDGE;
    else st6_d = tbo_pkg::STAGE_NONE;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
      v6_q <= v5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rv_q <= rv_d;   ed_q <= ed_d;   box1_q <= box1_d; id1_q <= id_i;  full1_q <= full_i;
      np_q <= np_d;   ep_q <= ep_d;   er_q <= er_d;     rv2_q <= rv_q[0];
      box2_q <= box1_q; id2_q <= id1_q; full2_q <= full1_q;
      n_q <= n_d;     rv3_q <= rv2_q; edge3_q <= edge3_d;
      box3_q <= box2_q; id3_q <= id2_q; full3_q <= full2_q;
      dl_q <= dl_d;   dh_q <= dh_d;   rl_q <= rl_d;     rh_q <= rh_d;
      edge4_q <= edge3_q; box4_q <= box3_q; id4_q <= id3_q; full4_q <= full3_q;
      sum_q <= sum_d; rad_q <= rad_d;
      edge5_q <= edge4_q; box5_q <= box4_q; id5_q <= id4_q; full5_q <= full4_q;
      st6_q <= st6_d; id6_q <= id5_q;
    end
  end

  assign out_valid_o = v6_q;
  assign stage_o     = st6_q;
  assign id_o        = id6_q;
endmodule

FILE: rtl/triangle_box_overlap_test.sv
// Top level of the triangle/box overlap test: stream ports, APB registers, output skid.
// Depends on tbo_pkg and tbo_core.
//
// Channel  Dir  Payload
// s_axis   in   tdata: nine vertex coordinates then tri_id
// m_axis   out  tdata: overlaps, reject_stage, tri_id_out
// apb      cfg  box center, half extents, full-test flag
//
// The datapath has six register stages and the output buffer adds one more register;
// one word per cycle is accepted while the pipeline is not held. Reset clears the valid
// bits, the buffer count and the configuration registers. A downstream stall holds the
// pipeline once the two-entry output buffer would otherwise overflow.
module triangle_box_overlap_test #(
  parameter int CoordBits = tbo_pkg::CoordBitsDef,
  parameter int IdBits    = tbo_pkg::IdBitsDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  // a_x,a_y,a_z,b_x,b_y,b_z,c_x,c_y,c_z,tri_id from the lowest bit
  input  logic [((9*CoordBits+IdBits+7)/8)*8-1:0] s_axis_tdata,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // overlaps, reject_stage, tri_id_out from the lowest bit
  output logic [((3+IdBits+7)/8)*8-1:0] m_axis_tdata,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [tbo_pkg::AddrBits-1:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready
);
  localparam int OB = ((3 + IdBits + 7) / 8) * 8;

  logic signed [2:0][CoordBits-1:0] ctr_q;
  logic [2:0][CoordBits-2:0] half_q;
  logic full_q;
  logic [2:0] ridx;

  assign pready = 1'b1;
  assign ridx   = paddr[4:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctr_q  <= '0;
      half_q <= '0;
      full_q <= 1'b0;
    end else if (psel && penable && pwrite) begin
      unique case (ridx)
        tbo_pkg::REG_CX:   ctr_q[0]  <= pwdata[CoordBits-1:0];
        tbo_pkg::REG_CY:   ctr_q[1]  <= pwdata[CoordBits-1:0];
        tbo_pkg::REG_CZ:   ctr_q[2]  <= pwdata[CoordBits-1:0];
        tbo_pkg::REG_HX:   half_q[0] <= pwdata[CoordBits-2:0];
        tbo_pkg::REG_HY:   half_q[1] <= pwdata[CoordBits-2:0];
        tbo_pkg::REG_HZ:   half_q[2] <= pwdata[CoordBits-2:0];
        tbo_pkg::REG_FULL: full_q    <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (ridx)
      tbo_pkg::REG_CX:   prdata = 32'($signed(ctr_q[0]));
      tbo_pkg::REG_CY:   prdata = 32'($signed(ctr_q[1]));
      tbo_pkg::REG_CZ:   prdata = 32'($signed(ctr_q[2]));
      tbo_pkg::REG_HX:   prdata = 32'(half_q[0]);
      tbo_pkg::REG_HY:   prdata = 32'(half_q[1]);
      tbo_pkg::REG_HZ:   prdata = 32'(half_q[2]);
      tbo_pkg::REG_FULL: prdata = 32'(full_q);
      default:           prdata = '0;
    endcase
  end

  logic signed [2:0][2:0][CoordBits-1:0] vtx;
  always_comb begin
    for (int i = 0; i < 3; i++)
      for (int k = 0; k < 3; k++)
        vtx[i][k] = s_axis_tdata[(3*i+k)*CoordBits +: CoordBits];
  end

  logic en, cv;
  tbo_pkg::stage_e cst;
  logic [IdBits-1:0] cid;

  // Two-entry output buffer; the pipeline is held only while it is full, not drained and a result is waiting.
  logic [1:0][OB-1:0] buf_q;
  logic [1:0] cnt_q;
  logic [OB-1:0] word;

  assign en            = (cnt_q == 2'd0) || (cnt_q == 2'd1 && m_axis_tready) || !cv
                         ? 1'b1 : (cnt_q == 2'd1) || m_axis_tready;
  assign s_axis_tready = en;

  tbo_core #(.CoordBits(CoordBits), .IdBits(IdBits)) u_core (
    .clk_i, .rst_ni, .en_i(en), .in_valid_i(s_axis_tvalid),
    .vtx_i(vtx), .id_i(s_axis_tdata[9*CoordBits +: IdBits]),
    .ctr_i(ctr_q), .half_i(half_q), .full_i(full_q),
    .out_valid_o(cv), .stage_o(cst), .id_o(cid)
  );

  assign word = OB'({cid, cst, cst == tbo_pkg::STAGE_NONE});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_q + 2'(cv && en) - 2'(m_axis_tvalid && m_axis_tready);
    end
  end

  always_ff @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) begin
      buf_q[0] <= (cnt_q == 2'd2) ? buf_q[1] : word;
      if (cnt_q == 2'd2 && cv && en) buf_q[1] <= word;
    end else if (cv && en) begin
      buf_q[cnt_q[0]] <= word;
    end
  end

  assign m_axis_tvalid = cnt_q != 2'd0;
  assign m_axis_tdata  = buf_q[0];
endmodule

FILE: tb/triangle_box_overlap_test_test.sv
// Testbench for the triangle/box overlap test: streams triangles against several box settings
// and checks every result word against a separating-axis predictor kept in a scoreboard class.
// Depends on tbo_pkg and triangle_box_overlap_test.
`timescale 1ns / 1ps

module triangle_box_overlap_test_test;
  localparam int CoordBits = tbo_pkg::CoordBitsDef;
  localparam int IdBits    = tbo_pkg::IdBitsDef;
  localparam int InBits    = ((9*CoordBits+IdBits+7)/8)*8;
  localparam int OutBits   = ((3+IdBits+7)/8)*8;
  localparam int CycleLimit = 400000;

  typedef logic signed [127:0] wide_t;
  typedef logic [InBits-1:0] tri_word_t;

  typedef struct {
    logic       hit;
    tbo_pkg::stage_e stage;
    logic [IdBits-1:0] id;
  } verdict_t;

  class overlap_board;
    wide_t center[3];
    wide_t half[3];
    bit full;
    verdict_t verdicts[$];
    int errors;

    function new();
      for (int k = 0; k < 3; k++) begin
        center[k] = 0;
        half[k] = 0;
      end
      full = 0;
      errors = 0;
    endfunction

    function void set_reg(tbo_pkg::reg_e idx, logic [31:0] val);
      if (idx <= tbo_pkg::REG_CZ) center[idx] = wide_t'(signed'(val[CoordBits-1:0]));
      else if (idx <= tbo_pkg::REG_HZ) half[idx - tbo_pkg::REG_HX] = wide_t'(val[CoordBits-2:0]);
      else full = val[0];
    endfunction

    function wide_t mag(wide_t a);
      return a < 0 ? -a : a;
    endfunction

    function wide_t reach(wide_t n0, wide_t n1, wide_t n2);
      return half[0]*mag(n0) + half[1]*mag(n1) + half[2]*mag(n2);
    endfunction

    function tbo_pkg::stage_e classify(tri_word_t w);
      wide_t v[3][3];
      wide_t e[3][3];
      wide_t n[3];
      wide_t s[3];
      wide_t u[3];
      wide_t lo, hi, p, r;
      for (int i = 0; i < 3; i++)
        for (int k = 0; k < 3; k++)
          v[i][k] = wide_t'(signed'(w[CoordBits*(3*i+k) +: CoordBits])) - center[k];
      for (int k = 0; k < 3; k++) begin
        lo = v[0][k];
        hi = v[0][k];
        for (int i = 1; i < 3; i++) begin
          if (v[i][k] < lo) lo = v[i][k];
          if (v[i][k] > hi) hi = v[i][k];
        end
        if (lo > half[k] || -half[k] > hi) return tbo_pkg::STAGE_BOX;
      end
      for (int k = 0; k < 3; k++) begin
        e[0][k] = v[1][k] - v[0][k];
        e[1][k] = v[2][k] - v[1][k];
        e[2][k] = v[0][k] - v[2][k];
      end
      n[0] = e[0][1]*e[1][2] - e[0][2]*e[1][1];
      n[1] = e[0][2]*e[1][0] - e[0][0]*e[1][2];
      n[2] = e[0][0]*e[1][1] - e[0][1]*e[1][0];
      p = n[0]*v[0][0] + n[1]*v[0][1] + n[2]*v[0][2];
      if (mag(p) > reach(n[0], n[1], n[2])) return tbo_pkg::STAGE_PLANE;
      if (full) begin
        for (int i = 0; i < 3; i++) begin
          for (int a = 0; a < 3; a++) begin
            for (int k = 0; k < 3; k++) u[k] = (k == a) ? 1 : 0;
            s[0] = e[i][1]*u[2] - e[i][2]*u[1];
            s[1] = e[i][2]*u[0] - e[i][0]*u[2];
            s[2] = e[i][0]*u[1] - e[i][1]*u[0];
            r = reach(s[0], s[1], s[2]);
            for (int k = 0; k < 3; k++) begin
              p = v[k][0]*s[0] + v[k][1]*s[1] + v[k][2]*s[2];
              if (k == 0 || p < lo) lo = p;
              if (k == 0 || p > hi) hi = p;
            end
            if (lo > r || -r > hi) return tbo_pkg::STAGE_EDGE;
          end
        end
      end
      return tbo_pkg::STAGE_NONE;
    endfunction

    function void note_triangle(tri_word_t w);
      verdict_t v;
      v.stage = classify(w);
      v.hit = (v.stage == tbo_pkg::STAGE_NONE);
      v.id = w[9*CoordBits +: IdBits];
      verdicts.push_back(v);
    endfunction

    function void check_result(logic [OutBits-1:0] d);
      verdict_t v;
      if (verdicts.size() == 0) begin
        $error("unexpected result word %h", d);
        errors++;
        return;
      end
      v = verdicts.pop_front();
      if (d[0] !== v.hit) begin
        $error("overlaps: expected %0d, got %0d", v.hit, d[0]);
        errors++;
      end
      if (d[2:1] !== v.stage) begin
        $error("reject_stage: expected %0d, got %0d", v.stage, d[2:1]);
        errors++;
      end
      if (d[3 +: IdBits] !== v.id) begin
        $error("tri_id_out: expected %0h, got %0h", v.id, d[3 +: IdBits]);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 0;
  logic rst_ni = 0;
  tri_word_t s_axis_tdata = '0;
  logic s_axis_tvalid = 0;
  logic s_axis_tready;
  logic [OutBits-1:0] m_axis_tdata;
  logic m_axis_tvalid;
  logic m_axis_tready = 0;
  logic psel = 0;
  logic penable = 0;
  logic pwrite = 0;
  logic [tbo_pkg::AddrBits-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  overlap_board board = new();
  int cycles = 0;
  int stall_mode = 0;

  always begin
    #2 clk_i = 1;
    #2 clk_i = 0;
  end

  triangle_box_overlap_test i_dut (
    .clk_i, .rst_ni,
    .s_axis_tdata, .s_axis_tvalid, .s_axis_tready,
    .m_axis_tdata, .m_axis_tvalid, .m_axis_tready,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
    if (m_axis_tvalid && m_axis_tready) board.check_result(m_axis_tdata);
    if (cycles % 128 == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: m_axis_tready <= 1;
      1: m_axis_tready <= ($urandom_range(0, 1) == 1);
      2: m_axis_tready <= (cycles % 7 < 3);
      default: m_axis_tready <= ($urandom_range(0, 9) == 0);
    endcase
  end

  task automatic write_reg(tbo_pkg::reg_e idx, logic [31:0] val);
    psel <= 1;
    penable <= 0;
    pwrite <= 1;
    paddr <= tbo_pkg::AddrBits'(4 * idx);
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1;
    @(posedge clk_i);
    board.set_reg(idx, val);
  endtask

  task automatic set_box(int cx, int cy, int cz, int hx, int hy, int hz, bit f);
    write_reg(tbo_pkg::REG_CX, {8'($urandom), 24'(cx)});
    write_reg(tbo_pkg::REG_CY, {8'($urandom), 24'(cy)});
    write_reg(tbo_pkg::REG_CZ, {8'($urandom), 24'(cz)});
    write_reg(tbo_pkg::REG_HX, {9'($urandom), 23'(hx)});
    write_reg(tbo_pkg::REG_HY, {9'($urandom), 23'(hy)});
    write_reg(tbo_pkg::REG_HZ, {9'($urandom), 23'(hz)});
    write_reg(tbo_pkg::REG_FULL, {31'($urandom), f});
    psel <= 0;
    penable <= 0;
  endtask

  task automatic send_triangle(tri_word_t w);
    s_axis_tvalid <= 1;
    s_axis_tdata <= w;
    do @(posedge clk_i); while (!s_axis_tready);
    board.note_triangle(w);
  endtask

  task automatic pause_sender();
    s_axis_tvalid <= 0;
    repeat ($urandom_range(1, 6)) @(posedge clk_i);
  endtask

  task automatic drain();
    s_axis_tvalid <= 0;
    while (board.verdicts.size() > 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
  endtask

  function automatic logic [CoordBits-1:0] near_coord(int c, int h);
    int span, v;
    span = 2 * h + 16;
    v = c + int'($urandom_range(0, 2 * span)) - span;
    if (v > 8388607) v = 8388607;
    if (v < -8388608) v = -8388608;
    return CoordBits'(v);
  endfunction

  function automatic tri_word_t random_triangle(bit noise);
    tri_word_t w;
    w = '0;
    for (int j = 0; j < 9; j++) begin
      if (noise) w[CoordBits*j +: CoordBits] = CoordBits'($urandom);
      else w[CoordBits*j +: CoordBits] =
          near_coord(int'(board.center[j%3]), int'(board.half[j%3]));
    end
    w[9*CoordBits +: IdBits] = IdBits'($urandom);
    return w;
  endfunction

  function automatic tri_word_t make_triangle(int ax, int ay, int az, int bx, int by,
                                              int bz, int cx, int cy, int cz, int id);
    tri_word_t w;
    w = '0;
    w[0 +: 216] = {24'(cz), 24'(cy), 24'(cx), 24'(bz), 24'(by), 24'(bx),
                   24'(az), 24'(ay), 24'(ax)};
    w[9*CoordBits +: IdBits] = IdBits'(id);
    return w;
  endfunction

  task automatic send_directed();
    send_triangle(make_triangle(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_triangle(make_triangle(-50, -50, 0, 50, -50, 0, 0, 50, 0, 1048575));
    send_triangle(make_triangle(300, 0, 0, 400, 5, 0, 350, 9, 1, 3));
    send_triangle(make_triangle(-50, -50, 20, 50, -50, 20, 0, 50, 20, 4));
    send_triangle(make_triangle(-50, -50, 100, 50, -50, 100, 0, 50, 100, 5));
    send_triangle(make_triangle(-300, 0, -300, 300, 0, 300, 300, 1, 300, 6));
    send_triangle(make_triangle(-150, 90, 0, 90, -150, 0, 0, 0, 150, 7));
    send_triangle(make_triangle(10, 10, 10, 10, 10, 10, 20, 20, 20, 8));
    pause_sender();
    send_triangle('1 >> (InBits - 9*CoordBits - IdBits));
    send_triangle(make_triangle(8388607, 8388607, 8388607, -8388608, -8388608, -8388608,
                                8388607, -8388608, 0, 9));
    send_triangle(make_triangle(-8388608, -8388608, -8388608, -8388608, -8388608,
                                -8388608, -8388608, -8388608, -8388608, 10));
    send_triangle(make_triangle(8388607, 0, 0, 0, 8388607, 0, 0, 0, 8388607, 11));
    send_triangle(make_triangle(-8388608, 8388607, 0, 8388607, -8388608, 0,
                                0, 0, -8388608, 12));
    send_triangle(make_triangle(100, 100, -100, 100, 100, 100, -100, 100, 0, 13));
    send_triangle(make_triangle(101, 0, 0, 200, 0, 0, 150, 50, 0, 14));
  endtask

  task automatic send_random(int count);
    int burst;
    burst = 0;
    for (int n = 0; n < count; n++) begin
      send_triangle(random_triangle($urandom_range(0, 4) == 0));
      if (burst == 0) begin
        burst = $urandom_range(1, 40);
        if ($urandom_range(0, 2) != 0) pause_sender();
      end else begin
        burst--;
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    send_directed();
    drain();
    set_box(0, 0, 0, 100, 100, 100, 1);
    send_directed();
    send_random(200);
    drain();
    set_box(-8388608, -8388608, -8388608, 8388607, 8388607, 8388607, 1);
    send_random(120);
    drain();
    set_box(8388607, 8388607, 8388607, 0, 0, 0, 0);
    send_random(80);
    drain();
    for (int p = 0; p < 8; p++) begin
      set_box(int'($urandom_range(0, 2000000)) - 1000000,
              int'($urandom_range(0, 2000000)) - 1000000,
              int'($urandom_range(0, 2000000)) - 1000000,
              $urandom_range(0, 5000), $urandom_range(0, 5000),
              $urandom_range(0, 5000), (p % 4 != 3));
      send_random(100);
      drain();
    end
    if (board.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
